FILE: rtl/core/point_project_to_screen_unit_assert.svh
// Assertion helpers for the projection unit.
`ifndef POINT_PROJECT_TO_SCREEN_UNIT_ASSERT_SVH
`define POINT_PROJECT_TO_SCREEN_UNIT_ASSERT_SVH

// Check that a condition implies a result in the same cycle.
`define PPS_ASSERT_IMPL(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (res)) \
        else $error("implication failed");

// Check that a condition implies a result in the following cycle.
`define PPS_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

    localparam int CLIP_W  = 50;   // signed clip value width
    localparam int NUM_W   = 51;   // numerator, denominator and remainder width
    localparam int TRY_W   = 53;   // trial remainder width
    localparam int DIV_N   = 20;   // quotient bits produced by the divider
    localparam int Q_W     = 21;   // quotient accumulator width
    localparam int SCR_W   = 18;
    localparam logic [SCR_W-1:0] SCREEN_MAX = 18'h3FFFF;

    localparam logic [2:0] REG_CLIP_X  = 3'd0;
    localparam logic [2:0] REG_CLIP_Y  = 3'd1;
    localparam logic [2:0] REG_CLIP_Z  = 3'd2;
    localparam logic [2:0] REG_CLIP_W  = 3'd3;
    localparam logic [2:0] REG_ORIG_X  = 3'd4;
    localparam logic [2:0] REG_ORIG_Y  = 3'd5;
    localparam logic [2:0] REG_WIDTH   = 3'd6;
    localparam logic [2:0] REG_HEIGHT  = 3'd7;

    typedef struct packed {
        logic [1:0]       inc;
        logic [NUM_W-1:0] rem;
    } div_step_t;

    // One restoring step of floor(a * k / b): shift, add a when the k bit
    // is set, then take out b up to twice (remainder stays below b).
    function automatic div_step_t div_step(input logic [NUM_W-1:0] r,
                                           input logic [NUM_W-1:0] a,
                                           input logic [NUM_W-1:0] b,
                                           input logic             kbit);
        logic [TRY_W-1:0] t;
        logic [TRY_W-1:0] bx;
        div_step_t        res;
        bx = {2'b00, b};
        t  = {1'b0, r, 1'b0} + (kbit ? {2'b00, a} : {TRY_W{1'b0}});
        res.inc = 2'd0;
        if (t >= bx) begin
            t = t - bx;
            res.inc = 2'd1;
        end
        if (t >= bx) begin
            t = t - bx;
            res.inc = 2'd2;
        end
        res.rem = t[NUM_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/point_project_to_screen_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Projects one Q16.16 point per request through a 4x4 Q8.8 matrix, clips it
// against the view volume and maps it to Q14.4 viewport pixels. It takes one
// request per clock unless a result is held, and passes each one through
// one multiply stage, two adder stages, one clip compare stage, 20 stages of
// a one-bit-per-stage restoring divider and one viewport adder stage. The
// whole pipeline advances together, halting only while a result is held.
// Write configuration only while the pipeline is empty.
module point_project_to_screen_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_visible,
    output logic [17:0]             m_screen_x,
    output logic [17:0]             m_screen_y
);

    localparam int NW = pps_pkg::NUM_W;
    localparam int CW = pps_pkg::CLIP_W;
    localparam int DN = pps_pkg::DIV_N;

    // configuration registers
    logic [63:0] coef_reg [0:3];
    logic [12:0] orig_x_reg, orig_y_reg;
    logic [13:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= 64'h100;
            coef_reg[1] <= 64'h1 << 24;
            coef_reg[2] <= 64'h1 << 40;
            coef_reg[3] <= 64'h1 << 56;
            orig_x_reg  <= 13'd0;
            orig_y_reg  <= 13'd0;
            width_reg   <= 14'd1280;
            height_reg  <= 14'd720;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pps_pkg::REG_CLIP_X: coef_reg[0] <= cfg_data;
                pps_pkg::REG_CLIP_Y: coef_reg[1] <= cfg_data;
                pps_pkg::REG_CLIP_Z: coef_reg[2] <= cfg_data;
                pps_pkg::REG_CLIP_W: coef_reg[3] <= cfg_data;
                pps_pkg::REG_ORIG_X: orig_x_reg  <= cfg_data[12:0];
                pps_pkg::REG_ORIG_Y: orig_y_reg  <= cfg_data[12:0];
                pps_pkg::REG_WIDTH:  width_reg   <= cfg_data[13:0];
                pps_pkg::REG_HEIGHT: height_reg  <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // global advance: move when the output slot is free or being taken
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: products
    logic              v1_reg;
    logic signed [47:0] prod_reg [0:3][0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 4; r++) begin
                prod_reg[r][0] <= $signed(coef_reg[r][15:0])  * s_point_x;
                prod_reg[r][1] <= $signed(coef_reg[r][31:16]) * s_point_y;
                prod_reg[r][2] <= $signed(coef_reg[r][47:32]) * s_point_z;
                prod_reg[r][3] <= {{16{coef_reg[r][63]}}, coef_reg[r][63:48], 16'h0};
            end
        end
    end

    // stage 2: pair sums
    logic               v2_reg;
    logic signed [48:0] pair_reg [0:3][0:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 4; r++) begin
                pair_reg[r][0] <= 49'(prod_reg[r][0]) + 49'(prod_reg[r][1]);
                pair_reg[r][1] <= 49'(prod_reg[r][2]) + 49'(prod_reg[r][3]);
            end
        end
    end

    // stage 3: clip coordinates
    logic                v3_reg;
    logic signed [CW-1:0] clip_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 4; r++) begin
                clip_reg[r] <= CW'(pair_reg[r][0]) + CW'(pair_reg[r][1]);
            end
        end
    end

    // stage 4: clip test, numerators and denominator
    logic signed [NW-1:0] cx, cy, cz, cw;
    logic signed [NW-1:0] wpx, wmx, wpy, wmy, wmz;
    logic                 vis_next;

    always_comb begin
        cx  = NW'(clip_reg[0]);
        cy  = NW'(clip_reg[1]);
        cz  = NW'(clip_reg[2]);
        cw  = NW'(clip_reg[3]);
        wpx = cw + cx;
        wmx = cw - cx;
        wpy = cw + cy;
        wmy = cw - cy;
        wmz = cw - cz;
        vis_next = (cw > 0) && !wpx[NW-1] && !wmx[NW-1] && !wpy[NW-1] && !wmy[NW-1]
                   && !cz[NW-1] && !wmz[NW-1];
    end

    // divider stages: index 0 is the divider input, index DN its output
    logic          dv_reg  [0:DN];
    logic          vis_reg [0:DN];
    logic [NW-1:0] nx_reg  [0:DN];
    logic [NW-1:0] ny_reg  [0:DN];
    logic [NW-1:0] den_reg [0:DN];
    logic [NW-1:0] rx_reg  [0:DN];
    logic [NW-1:0] ry_reg  [0:DN];
    logic [pps_pkg::Q_W-1:0] qx_reg [0:DN];
    logic [pps_pkg::Q_W-1:0] qy_reg [0:DN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vis_reg[0] <= vis_next;
            nx_reg[0]  <= wpx;
            ny_reg[0]  <= wmy;
            den_reg[0] <= cw <<< 1;
            rx_reg[0]  <= '0;
            ry_reg[0]  <= '0;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
        end
    end

    // scale factors: pixel size times 16
    logic [DN-1:0] kx, ky;
    assign kx = DN'({width_reg, 4'h0});
    assign ky = DN'({height_reg, 4'h0});

    for (genvar j = 0; j < DN; j++) begin : g_div
        pps_pkg::div_step_t sx, sy;

        assign sx = pps_pkg::div_step(rx_reg[j], nx_reg[j], den_reg[j], kx[DN-1-j]);
        assign sy = pps_pkg::div_step(ry_reg[j], ny_reg[j], den_reg[j], ky[DN-1-j]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                vis_reg[j+1] <= vis_reg[j];
                nx_reg[j+1]  <= nx_reg[j];
                ny_reg[j+1]  <= ny_reg[j];
                den_reg[j+1] <= den_reg[j];
                rx_reg[j+1]  <= sx.rem;
                ry_reg[j+1]  <= sy.rem;
                qx_reg[j+1]  <= {qx_reg[j][pps_pkg::Q_W-2:0], 1'b0}
                                + pps_pkg::Q_W'(sx.inc);
                qy_reg[j+1]  <= {qy_reg[j][pps_pkg::Q_W-2:0], 1'b0}
                                + pps_pkg::Q_W'(sy.inc);
            end
        end
    end

    // final stage: add origin, saturate, zero when clipped
    logic [21:0]      sum_x, sum_y;
    logic [17:0]      scr_x_next, scr_y_next;
    logic             out_valid_reg, out_vis_reg;
    logic [17:0]      out_x_reg, out_y_reg;

    always_comb begin
        sum_x = {5'h0, orig_x_reg, 4'h0} + 22'(qx_reg[DN]);
        sum_y = {5'h0, orig_y_reg, 4'h0} + 22'(qy_reg[DN]);
        scr_x_next = (sum_x > 22'(pps_pkg::SCREEN_MAX)) ? pps_pkg::SCREEN_MAX : sum_x[17:0];
        scr_y_next = (sum_y > 22'(pps_pkg::SCREEN_MAX)) ? pps_pkg::SCREEN_MAX : sum_y[17:0];
        if (!vis_reg[DN]) begin
            scr_x_next = '0;
            scr_y_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_reg[DN];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_vis_reg <= vis_reg[DN];
            out_x_reg   <= scr_x_next;
            out_y_reg   <= scr_y_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_visible  = out_vis_reg;
    assign m_screen_x = out_x_reg;
    assign m_screen_y = out_y_reg;

`include "point_project_to_screen_unit_assert.svh"

    `PPS_ASSERT_IMPL(a_clip_zero, aclk, aresetn, m_valid && !m_visible, m_screen_x == 18'd0 && m_screen_y == 18'd0)
    `PPS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !adv, $stable(dv_reg[DN]) && $stable(v1_reg))
    `PPS_ASSERT_NEXT(a_out_load, aclk, aresetn, adv && dv_reg[DN], m_valid)

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic        vis;
        logic [17:0] sx;
        logic [17:0] sy;
    } screen_hit_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = pps_pkg::REG_CLIP_X;
    logic [63:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_point_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_visible;
    logic [17:0]        m_screen_x;
    logic [17:0]        m_screen_y;

    // shadow copy of the configuration registers
    logic [63:0] row_coeffs [4];
    logic [12:0] view_org_x;
    logic [12:0] view_org_y;
    logic [13:0] view_w;
    logic [13:0] view_h;

    screen_hit_t pending_hits [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    point_project_to_screen_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_point_z  (s_point_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_visible  (m_visible),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Q24.24 dot product of [x y z 1] with four Q8.8 lanes
    function automatic longint clip_dot(input logic [63:0] c, input longint x,
                                        input longint y, input longint z);
        return longint'($signed(c[15:0])) * x + longint'($signed(c[31:16])) * y +
               longint'($signed(c[47:32])) * z + longint'($signed(c[63:48])) * 65536;
    endfunction

    function automatic logic [17:0] viewport_coord(input logic [12:0] org,
                                                   input logic [13:0] size,
                                                   input longint num, input longint den);
        logic [127:0] q;
        logic [127:0] v;
        q = (128'(num) * 128'(size) * 128'd16) / 128'(den);
        v = 128'(org) * 128'd16 + q;
        return (v > 128'd262143) ? pps_pkg::SCREEN_MAX : v[17:0];
    endfunction

    function automatic screen_hit_t project_point(input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz);
        longint      cx, cy, cz, cw;
        screen_hit_t hit;
        cx = clip_dot(row_coeffs[0], px, py, pz);
        cy = clip_dot(row_coeffs[1], px, py, pz);
        cz = clip_dot(row_coeffs[2], px, py, pz);
        cw = clip_dot(row_coeffs[3], px, py, pz);
        hit = '0;
        if (cw > 0 && cx >= -cw && cx <= cw && cy >= -cw && cy <= cw &&
            cz >= 0 && cz <= cw) begin
            hit.vis = 1'b1;
            hit.sx  = viewport_coord(view_org_x, view_w, cw + cx, 2 * cw);
            hit.sy  = viewport_coord(view_org_y, view_h, cw - cy, 2 * cw);
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // predict every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_hits = {pending_hits, project_point(s_point_x, s_point_y, s_point_z)};
    end

    // compare every accepted result with the oldest prediction
    always @(posedge aclk) begin
        screen_hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result, queue depth", 0, 0);
            end else begin
                want = pending_hits.pop_front();
                if (m_visible !== want.vis)
                    report_mismatch("visible", m_visible, want.vis);
                if (m_screen_x !== want.sx)
                    report_mismatch("screen_x", m_screen_x, want.sx);
                if (m_screen_y !== want.sy)
                    report_mismatch("screen_y", m_screen_y, want.sy);
            end
        end
    end

    // stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pps_pkg::REG_CLIP_X: row_coeffs[0] = value;
            pps_pkg::REG_CLIP_Y: row_coeffs[1] = value;
            pps_pkg::REG_CLIP_Z: row_coeffs[2] = value;
            pps_pkg::REG_CLIP_W: row_coeffs[3] = value;
            pps_pkg::REG_ORIG_X: view_org_x = value[12:0];
            pps_pkg::REG_ORIG_Y: view_org_y = value[12:0];
            pps_pkg::REG_WIDTH:  view_w = value[13:0];
            default:             view_h = value[13:0];
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [63:0] lanes(input int cx, input int cy, input int cz,
                                          input int ck);
        return {16'(ck), 16'(cz), 16'(cy), 16'(cx)};
    endfunction

    function automatic logic signed [31:0] rand_word();
        return $urandom();
    endfunction

    // reset matrix: identity, unit box visible
    task automatic test_identity();
        send_point(0, 0, 0);
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        send_point(-32'sd65536, -32'sd65536, 0);
        send_point(-32'sd65536, 32'sd65536, 32'sd32768);
        send_point(32'sd65537, 0, 0);
        send_point(0, -32'sd65537, 0);
        send_point(0, 0, -32'sd1);
        send_point(0, 0, 32'sd65537);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'sd12345, -32'sd4321, 32'sd999);
        drain_pipeline();
    endtask

    // large origin and size bring both axes near, but not past, the top of the range
    task automatic test_saturation();
        write_reg(pps_pkg::REG_ORIG_X, 64'd8191);
        write_reg(pps_pkg::REG_ORIG_Y, 64'd8191);
        write_reg(pps_pkg::REG_WIDTH, 64'd8192);
        write_reg(pps_pkg::REG_HEIGHT, 64'd8192);
        send_point(32'sd65536, -32'sd65536, 32'sd65536);
        send_point(0, 0, 0);
        send_point(-32'sd65536, 32'sd65536, 0);
        drain_pipeline();
    endtask

    // zero size leaves only the origin; wide writes keep the low bits
    task automatic test_zero_size_and_wide();
        write_reg(pps_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_C000);
        write_reg(pps_pkg::REG_HEIGHT, 64'h0);
        write_reg(pps_pkg::REG_ORIG_X, 64'hFFFF_FFFF_FFFF_E123);
        write_reg(pps_pkg::REG_ORIG_Y, 64'h0000_0000_0000_2005);
        send_point(32'sd30000, 32'sd30000, 32'sd100);
        send_point(-32'sd65536, 0, 32'sd65536);
        drain_pipeline();
        write_reg(pps_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pps_pkg::REG_HEIGHT, 64'd1);
        send_point(32'sd65536, -32'sd65536, 32'sd65536);
        send_point(-32'sd100, 32'sd100, 32'sd1);
        drain_pipeline();
    endtask

    // extreme matrices: all ones, most negative lanes, a zero w row, then a large w row alone
    task automatic test_extreme_matrix();
        write_reg(pps_pkg::REG_CLIP_X, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pps_pkg::REG_CLIP_Y, 64'h8000_8000_8000_8000);
        write_reg(pps_pkg::REG_CLIP_Z, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(pps_pkg::REG_CLIP_W, 64'h0);
        send_point(32'sd65536, 32'sd65536, 32'sd65536);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        drain_pipeline();
        write_reg(pps_pkg::REG_CLIP_W, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(pps_pkg::REG_CLIP_X, 64'h0);
        write_reg(pps_pkg::REG_CLIP_Y, 64'h0);
        write_reg(pps_pkg::REG_CLIP_Z, 64'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(0, 0, 0);
        drain_pipeline();
    endtask

    // pick a camera: orthographic box or perspective divide by z
    task automatic load_random_view();
        int persp;
        persp = $urandom_range(1);
        write_reg(pps_pkg::REG_CLIP_X,
                  lanes($urandom_range(512, 32), $urandom_range(32) - 16,
                        $urandom_range(32) - 16, $urandom_range(64) - 32));
        write_reg(pps_pkg::REG_CLIP_Y,
                  lanes($urandom_range(32) - 16, $urandom_range(512, 32),
                        $urandom_range(32) - 16, $urandom_range(64) - 32));
        write_reg(pps_pkg::REG_CLIP_Z,
                  lanes(0, 0, $urandom_range(256, 64), $urandom_range(64) - 32));
        if (persp != 0)
            write_reg(pps_pkg::REG_CLIP_W, lanes(0, 0, 256, $urandom_range(16)));
        else
            write_reg(pps_pkg::REG_CLIP_W, lanes(0, 0, 0, $urandom_range(512, 1)));
        write_reg(pps_pkg::REG_ORIG_X, $urandom_range(8191));
        write_reg(pps_pkg::REG_ORIG_Y, $urandom_range(8191));
        write_reg(pps_pkg::REG_WIDTH, $urandom_range(8192, 1));
        write_reg(pps_pkg::REG_HEIGHT, $urandom_range(8192, 1));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                drain_pipeline();
                if ($urandom_range(4) == 0) begin
                    write_reg(pps_pkg::REG_CLIP_X, {$urandom(), $urandom()});
                    write_reg(pps_pkg::REG_CLIP_W, {$urandom(), $urandom()});
                end else begin
                    load_random_view();
                end
            end
            if ($urandom_range(99) < 75)
                send_point($urandom_range(262144) - 131072, $urandom_range(262144) - 131072,
                           $urandom_range(212992) - 16384);
            else
                send_point(rand_word(), rand_word(), rand_word());
        end
        // hold off until the pipeline is empty
        drain_pipeline();
    endtask

    initial begin
        row_coeffs[0] = 64'h100;
        row_coeffs[1] = 64'h1 << 24;
        row_coeffs[2] = 64'h1 << 40;
        row_coeffs[3] = 64'h1 << 56;
        view_org_x = '0;
        view_org_y = '0;
        view_w = 14'd1280;
        view_h = 14'd720;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity();
        test_saturation();
        test_zero_size_and_wide();
        test_extreme_matrix();
        test_random_phase(0, 0, 190);
        test_random_phase(85, 0, 180);
        test_random_phase(0, 85, 190);
        test_random_phase(11, 11, 190);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/point_project_to_screen_unit.sv
sim/testbench.sv
